### src/sbsa_pkg.sv
// ============================================================================
// sbsa_pkg
// Shared types and constants of the slot bitmap scratch allocator.
// ============================================================================
`default_nettype none

package sbsa_pkg;

  // Default sizing of the slot table and of the offset datapath.
  localparam int unsigned SLOTS_DEF       = 32;
  localparam int unsigned OFFSET_BITS_DEF = 16;

  // Reset value of the buffer size register.
  localparam logic [15:0] BUF_BYTES_RESET = 16'd2000;

  // Shrink lengths are rounded up to a multiple of eight bytes.
  localparam logic [2:0] ROUND_MASK = 3'h7;

  // Operation codes carried in the input tuser.
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SHRINK  = 2'd2
  } op_e;

  // Result codes carried in the output tuser.
  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_REUSED   = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_RELEASED = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_SHRUNK   = 3'd5,
    ST_IGNORED  = 3'd6
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_AL_PREP,
    S_AL_SCAN,
    S_RL_FAST,
    S_RL_SCAN,
    S_RL_HIT,
    S_RL_TOP,
    S_SH_CALC,
    S_SH_WRITE,
    S_DONE
  } state_e;

  // One request as taken from the input channel.
  typedef struct packed {
    op_e                op;
    logic signed [16:0] size;
    logic [15:0]        addr;
  } req_t;

  // One result as handed to the output channel.
  typedef struct packed {
    status_e     status;
    logic [15:0] base;
    logic [15:0] len;
    logic [4:0]  slot;
  } result_t;

  // Slot table commands from the sequencer.
  typedef struct packed {
    logic wr;   // write base and length at the index
    logic clr;  // clear the index and every higher entry
  } tbl_cmd_t;

endpackage

`default_nettype wire

### src/sbsa_slot_table.sv
// ============================================================================
// sbsa_slot_table
// Base and length of every slot, one shared read/write index, plus a
// clear of all entries from the index upward.
// ============================================================================
`default_nettype none

module sbsa_slot_table #(
  parameter int unsigned SLOTS       = 32,
  parameter int unsigned OFFSET_BITS = 16,
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned LW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  sbsa_pkg::tbl_cmd_t     cmd_i,
  input  wire [IW-1:0]           idx_i,
  input  wire [OFFSET_BITS-1:0]  wr_base_i,
  input  wire [LW-1:0]           wr_len_i,
  output logic [OFFSET_BITS-1:0] rd_base_o,
  output logic [LW-1:0]          rd_len_o
);
  import sbsa_pkg::*;

  logic [OFFSET_BITS-1:0] base_q [SLOTS];
  logic [LW-1:0]          len_q  [SLOTS];

  // Each entry decides on its own whether it is written or cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        base_q[i] <= '0;
        len_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (cmd_i.clr && (IW'(i) >= idx_i)) begin
          base_q[i] <= '0;
          len_q[i]  <= '0;
        end else if (cmd_i.wr && (IW'(i) == idx_i)) begin
          base_q[i] <= wr_base_i;
          len_q[i]  <= wr_len_i;
        end
      end
    end
  end

  // The sequencer looks at one entry per cycle.
  assign rd_base_o = base_q[idx_i];
  assign rd_len_o  = len_q[idx_i];

endmodule

`default_nettype wire

### src/sbsa_engine.sv
// ============================================================================
// sbsa_engine
// Sequencer of the allocator: walks the slot table one entry per cycle
// through a shared compare path and keeps bitmap, bump pointer and last slot.
// ============================================================================
`default_nettype none

module sbsa_engine #(
  parameter int unsigned SLOTS       = 32,
  parameter int unsigned OFFSET_BITS = 16,
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned LW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start_i,
  input  sbsa_pkg::req_t         req_i,
  input  wire [15:0]             buf_bytes_i,
  output logic                   idle_o,
  output logic                   res_valid_o,
  input  wire                    res_ready_i,
  output sbsa_pkg::result_t      res_o,
  output sbsa_pkg::tbl_cmd_t     tbl_cmd_o,
  output logic [IW-1:0]          tbl_idx_o,
  output logic [OFFSET_BITS-1:0] tbl_wr_base_o,
  output logic [LW-1:0]          tbl_wr_len_o,
  input  wire [OFFSET_BITS-1:0]  tbl_rd_base_i,
  input  wire [LW-1:0]           tbl_rd_len_i
);
  import sbsa_pkg::*;

  localparam int unsigned CW      = LW + 1;
  localparam logic [IW-1:0] LAST_IX = IW'(SLOTS - 1);
  localparam logic [CW-1:0] OFF_MASK = CW'((64'd1 << OFFSET_BITS) - 64'd1);

  state_e                 state_q, state_d;
  req_t                   req_q, req_d;
  logic [SLOTS-1:0]       used_q, used_d;
  logic [OFFSET_BITS-1:0] free_ptr_q, free_ptr_d;
  logic                   last_v_q, last_v_d;
  logic [IW-1:0]          last_idx_q, last_idx_d;
  logic [IW-1:0]          ix_q, ix_d;
  logic [15:0]            avail_q, avail_d;
  logic [15:0]            size_q, size_d;
  logic [16:0]            shr_len_q, shr_len_d;
  logic [CW-1:0]          room_q, room_d;
  result_t                res_q, res_d;

  logic [CW-1:0]    addr_ext, base_ext, end_ext, fp_ext, buf_ext;
  logic [CW-1:0]    len_fin;
  logic [15:0]      avail_w;
  logic [16:0]      round_w;
  logic             holds;
  logic             rest_free;
  logic             hit_top;
  logic [SLOTS-1:0] used_hit_clr;
  logic [IW-1:0]    ix_prev;

  function automatic logic [15:0] f16(input logic [CW-1:0] v);
    return v[15:0];
  endfunction

  function automatic result_t mk_res(input status_e st, input logic [15:0] b,
                                     input logic [15:0] l, input logic [4:0] s);
    result_t r;
    r.status = st;
    r.base   = b;
    r.len    = l;
    r.slot   = s;
    return r;
  endfunction

  // Shared compare path on the table entry under the index.
  assign addr_ext  = CW'(req_q.addr);
  assign base_ext  = CW'(tbl_rd_base_i);
  assign end_ext   = base_ext + CW'(tbl_rd_len_i);
  assign holds     = (addr_ext >= base_ext) && (addr_ext < end_ext);
  assign fp_ext    = CW'(free_ptr_q);
  assign buf_ext   = CW'(buf_bytes_i);
  assign avail_w   = (buf_ext > fp_ext) ? 16'(buf_ext - fp_ext) : 16'd0;
  assign rest_free = ((used_q >> ix_q) == '0);

  // Release bookkeeping: bitmap without the hit and the scan below it.
  assign used_hit_clr = used_q & ~(SLOTS'(1) << ix_q);
  assign hit_top      = ((used_hit_clr >> ix_q) == '0);
  assign ix_prev      = ix_q - IW'(1);

  // Shrink length rounded up and limited to the room below the top offset.
  assign round_w = (17'({1'b0, req_q.size[15:0]}) + 17'(ROUND_MASK)) & ~17'(ROUND_MASK);
  assign len_fin = (CW'(shr_len_q) > room_q) ? room_q : CW'(shr_len_q);

  // Next state and table commands.
  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    used_d        = used_q;
    free_ptr_d    = free_ptr_q;
    last_v_d      = last_v_q;
    last_idx_d    = last_idx_q;
    ix_d          = ix_q;
    avail_d       = avail_q;
    size_d        = size_q;
    shr_len_d     = shr_len_q;
    room_d        = room_q;
    res_d         = res_q;
    tbl_cmd_o     = '0;
    tbl_idx_o     = ix_q;
    tbl_wr_base_o = free_ptr_q;
    tbl_wr_len_o  = LW'(size_q);
    res_valid_o   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          case (req_i.op)
            OP_ALLOC:   state_d = S_AL_PREP;
            OP_RELEASE: state_d = S_RL_FAST;
            OP_SHRINK:  state_d = S_SH_CALC;
            default: begin
              res_d   = mk_res(ST_IGNORED, '0, '0, '0);
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Resolve the requested size against the free space.
      S_AL_PREP: begin
        avail_d = avail_w;
        ix_d    = '0;
        state_d = S_AL_SCAN;
        if (req_q.size == 17'sd0) begin
          size_d = avail_w;
        end else if (req_q.size == -17'sd1) begin
          size_d = avail_w >> 1;
        end else if (req_q.size[16]) begin
          res_d   = mk_res(ST_NOSPACE, '0, '0, '0);
          state_d = S_DONE;
        end else begin
          size_d = req_q.size[15:0];
        end
      end

      // Reuse the lowest exact-size hole, else carve from the bump pointer.
      S_AL_SCAN: begin
        if (!used_q[ix_q] && rest_free) begin
          state_d = S_DONE;
          if (size_q <= avail_q) begin
            tbl_cmd_o.wr   = 1'b1;
            free_ptr_d     = OFFSET_BITS'(fp_ext + CW'(size_q));
            used_d[ix_q]   = 1'b1;
            last_v_d       = 1'b1;
            last_idx_d     = ix_q;
            res_d = mk_res(ST_NEW, f16(fp_ext), size_q, 5'(ix_q));
          end else begin
            res_d = mk_res(ST_NOSPACE, '0, '0, '0);
          end
        end else if (!used_q[ix_q] && (tbl_rd_len_i == LW'(size_q))) begin
          used_d[ix_q] = 1'b1;
          res_d = mk_res(ST_REUSED, f16(base_ext), f16(CW'(tbl_rd_len_i)), 5'(ix_q));
          state_d = S_DONE;
        end else if (ix_q == LAST_IX) begin
          res_d   = mk_res(ST_NOSPACE, '0, '0, '0);
          state_d = S_DONE;
        end else begin
          ix_d = ix_q + IW'(1);
        end
      end

      // Try the last allocated slot before a full search.
      S_RL_FAST: begin
        ix_d    = '0;
        state_d = S_RL_SCAN;
        if (last_v_q) begin
          tbl_idx_o = last_idx_q;
          if (used_q[last_idx_q] && holds) begin
            ix_d    = last_idx_q;
            state_d = S_RL_HIT;
          end else begin
            last_v_d = 1'b0;
          end
        end
      end

      S_RL_SCAN: begin
        if (used_q[ix_q] && holds) begin
          state_d = S_RL_HIT;
        end else if (ix_q == LAST_IX) begin
          res_d   = mk_res(ST_NOTFOUND, '0, '0, '0);
          state_d = S_DONE;
        end else begin
          ix_d = ix_q + IW'(1);
        end
      end

      // Free the slot; fall back the bump pointer if it was the top one.
      S_RL_HIT: begin
        used_d  = used_hit_clr;
        res_d   = mk_res(ST_RELEASED, f16(base_ext), f16(CW'(tbl_rd_len_i)), 5'(ix_q));
        state_d = hit_top ? S_RL_TOP : S_DONE;
      end

      // Walk down to the slot just above the highest one still in use.
      S_RL_TOP: begin
        if ((ix_q == '0) || used_q[ix_prev]) begin
          free_ptr_d    = tbl_rd_base_i;
          tbl_cmd_o.clr = 1'b1;
          state_d       = S_DONE;
        end else begin
          ix_d = ix_prev;
        end
      end

      S_SH_CALC: begin
        tbl_idx_o = last_idx_q;
        if (!last_v_q || (base_ext != addr_ext)) begin
          res_d   = mk_res(ST_IGNORED, '0, '0, '0);
          state_d = S_DONE;
        end else begin
          shr_len_d = (req_q.size[16] || (req_q.size == 17'sd0)) ? 17'd0 : round_w;
          room_d    = (addr_ext <= OFF_MASK) ? (OFF_MASK - addr_ext) : '0;
          state_d   = S_SH_WRITE;
        end
      end

      S_SH_WRITE: begin
        tbl_idx_o     = last_idx_q;
        tbl_cmd_o.wr  = 1'b1;
        tbl_wr_base_o = tbl_rd_base_i;
        tbl_wr_len_o  = LW'(len_fin);
        free_ptr_d    = OFFSET_BITS'(addr_ext + len_fin);
        res_d   = mk_res(ST_SHRUNK, req_q.addr, f16(len_fin), 5'(last_idx_q));
        state_d = S_DONE;
      end

      // Hold the result until the output register takes it.
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      used_q     <= '0;
      free_ptr_q <= '0;
      last_v_q   <= 1'b0;
      last_idx_q <= '0;
      ix_q       <= '0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      free_ptr_q <= free_ptr_d;
      last_v_q   <= last_v_d;
      last_idx_q <= last_idx_d;
      ix_q       <= ix_d;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    avail_q   <= avail_d;
    size_q    <= size_d;
    shr_len_q <= shr_len_d;
    room_q    <= room_d;
    res_q     <= res_d;
  end

  assign idle_o = (state_q == S_IDLE);
  assign res_o  = res_q;

endmodule

`default_nettype wire

### src/slot_bitmap_scratch_allocator_core.sv
// ============================================================================
// slot_bitmap_scratch_allocator_core
// Scratch buffer allocator with a used bitmap, a slot table and a bump
// pointer; allocate, release by address and shrink of the last block.
// ============================================================================
//
//  Channel  Direction  Beat content
//  -------  ---------  ------------------------------------------------------
//  s_axis   in         tuser: op; tdata: req_size, req_addr
//  m_axis   out        tuser: status; tdata: block_base, block_len, slot_index
//  cfg      in         buffer_bytes (16 bit)
//
//  Allocate and release scan one slot table entry per cycle through the
//  compare path; shrink reads only the last slot and the spare op none.
//  The result beat follows the last busy cycle; input is ready only when idle.
//  Reset clears the bitmap, the slot table and the pointers at once.
//  A full output register stalls the sequencer in its result state.
// ============================================================================
`default_nettype none

module slot_bitmap_scratch_allocator_core #(
  parameter int unsigned SLOTS       = sbsa_pkg::SLOTS_DEF,
  parameter int unsigned OFFSET_BITS = sbsa_pkg::OFFSET_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [15:0] cfg_data_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // req_size[16:0], req_addr[32:17], zero
  input  wire  [1:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // block_base[15:0], block_len[31:16],
                                      // slot_index[36:32], zero
  output logic [2:0]  m_axis_tuser    // status
);
  import sbsa_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

  logic [15:0]            buf_bytes_q;
  logic                   out_valid_q;
  result_t                out_res_q;
  req_t                   req;
  logic                   start;
  logic                   idle;
  logic                   res_valid;
  logic                   out_free;
  result_t                res;
  tbl_cmd_t               tbl_cmd;
  logic [IW-1:0]          tbl_idx;
  logic [OFFSET_BITS-1:0] tbl_wr_base, tbl_rd_base;
  logic [LW-1:0]          tbl_wr_len, tbl_rd_len;

  // Buffer size register, written at any time the block is idle.
  assign cfg_ready_o = idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_bytes_q <= BUF_BYTES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      buf_bytes_q <= cfg_data_i;
    end
  end

  // Input beat unpacking.
  assign req.op        = op_e'(s_axis_tuser);
  assign req.size      = s_axis_tdata[16:0];
  assign req.addr      = s_axis_tdata[32:17];
  assign s_axis_tready = idle;
  assign start         = s_axis_tvalid && idle;

  sbsa_engine #(
    .SLOTS       (SLOTS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .req_i         (req),
    .buf_bytes_i   (buf_bytes_q),
    .idle_o        (idle),
    .res_valid_o   (res_valid),
    .res_ready_i   (out_free),
    .res_o         (res),
    .tbl_cmd_o     (tbl_cmd),
    .tbl_idx_o     (tbl_idx),
    .tbl_wr_base_o (tbl_wr_base),
    .tbl_wr_len_o  (tbl_wr_len),
    .tbl_rd_base_i (tbl_rd_base),
    .tbl_rd_len_i  (tbl_rd_len)
  );

  sbsa_slot_table #(
    .SLOTS       (SLOTS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (tbl_cmd),
    .idx_i     (tbl_idx),
    .wr_base_i (tbl_wr_base),
    .wr_len_i  (tbl_wr_len),
    .rd_base_o (tbl_rd_base),
    .rd_len_o  (tbl_rd_len)
  );

  // Output register; it takes a new result as soon as the old one leaves.
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.status;
  assign m_axis_tdata  = {3'b000, out_res_q.slot, out_res_q.len, out_res_q.base};

  // An accepted request makes the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !s_axis_tready)
    else $error("input still ready after a request was taken");

  // A result blocked by a full output register is held unchanged.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !out_free) |=> (res_valid && $stable(res)))
    else $error("pending result lost or changed while output was full");

  // Failure and ignore results carry no block information.
  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((out_res_q.status == ST_NOSPACE) ||
                     (out_res_q.status == ST_NOTFOUND) ||
                     (out_res_q.status == ST_IGNORED)))
    |-> ((out_res_q.base == '0) && (out_res_q.len == '0) && (out_res_q.slot == '0)))
    else $error("error result with nonzero block fields");

endmodule

`default_nettype wire

### tb/tb_slot_bitmap_scratch_allocator_core.sv
// ----------------------------------------------------------------------------
// Scratch allocator core testbench
// Drives allocate, release and shrink requests through the stream input,
// predicts every result from a private copy of the slot table and checks the
// output beats in order, under random sender bursts and receiver stalls and
// across several buffer sizes from zero to the full offset range.
// ----------------------------------------------------------------------------
module tb_slot_bitmap_scratch_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sbsa_pkg::*;

  localparam int unsigned TBL_SLOTS   = SLOTS_DEF;
  localparam int          CYCLE_LIMIT = 800000;
  localparam logic [1:0]  OP_SPARE    = 2'd3;

  // Expected content of one output beat.
  typedef struct packed {
    status_e     status;
    logic [15:0] base;
    logic [15:0] len;
    logic [4:0]  slot;
  } grant_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  slot_bitmap_scratch_allocator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the allocator state.
  logic [31:0] used_map;
  logic [15:0] tbl_base [TBL_SLOTS];
  logic [15:0] tbl_len  [TBL_SLOTS];
  logic [15:0] bump_ptr;
  int          last_ix;
  logic [15:0] buf_size;

  grant_t pending_grants [$];

  int mismatches  = 0;
  int unexpected  = 0;
  int checked     = 0;
  int cfg_writes  = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int op_count     [4];
  int status_hist  [8];

  // Receiver pattern state.
  int rx_mode  = 0;
  int rx_left  = 0;
  int rx_phase = 0;

  function automatic bit slot_holds(int ix, logic [15:0] addr);
    return int'(addr) >= int'(tbl_base[ix]) &&
           int'(addr) < int'(tbl_base[ix]) + int'(tbl_len[ix]);
  endfunction

  // Applies one request to the shadow state and returns the expected beat.
  function automatic grant_t predict_grant(logic [1:0] op, logic signed [16:0] size_f,
                                           logic [15:0] addr);
    grant_t      r;
    int          sz;
    int          avail;
    int          ix;
    int          hit;
    int          top;
    int          start;
    int          nlen;
    int          room;
    bit          done;
    r = '{status: ST_IGNORED, base: '0, len: '0, slot: '0};
    sz = size_f;
    done = 1'b0;
    case (op)
      OP_ALLOC: begin
        avail = (buf_size > bump_ptr) ? int'(buf_size) - int'(bump_ptr) : 0;
        if (sz == 0) sz = avail;
        else if (sz == -1) sz = avail / 2;
        r.status = ST_NOSPACE;
        if (sz >= 0) begin
          for (ix = 0; ix < TBL_SLOTS && !done; ix++) begin
            if (!used_map[ix]) begin
              if ((used_map >> ix) == 32'd0) begin
                // Top of the table: cut a new block from the bump pointer.
                if (sz <= avail) begin
                  r = '{status: ST_NEW, base: bump_ptr, len: sz[15:0], slot: ix[4:0]};
                  tbl_base[ix] = bump_ptr;
                  tbl_len[ix]  = sz[15:0];
                  bump_ptr     = bump_ptr + sz[15:0];
                  used_map[ix] = 1'b1;
                  last_ix      = ix;
                end
                done = 1'b1;
              end else if (int'(tbl_len[ix]) == sz) begin
                // A hole of exactly the requested length is reused.
                used_map[ix] = 1'b1;
                r = '{status: ST_REUSED, base: tbl_base[ix], len: tbl_len[ix],
                      slot: ix[4:0]};
                done = 1'b1;
              end
            end
          end
        end
      end
      OP_RELEASE: begin
        hit = -1;
        if (last_ix >= 0) begin
          if (used_map[last_ix] && slot_holds(last_ix, addr)) hit = last_ix;
          else last_ix = -1;
        end
        for (ix = 0; ix < TBL_SLOTS && hit < 0; ix++)
          if (used_map[ix] && slot_holds(ix, addr)) hit = ix;
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r = '{status: ST_RELEASED, base: tbl_base[hit], len: tbl_len[hit],
                slot: hit[4:0]};
          used_map[hit] = 1'b0;
          // Nothing used above: fall back to the slot over the highest used one.
          if ((used_map >> hit) == 32'd0) begin
            top = -1;
            for (ix = 0; ix < hit; ix++)
              if (used_map[ix]) top = ix;
            start = top + 1;
            bump_ptr = tbl_base[start];
            for (ix = start; ix < TBL_SLOTS; ix++) begin
              tbl_base[ix] = '0;
              tbl_len[ix]  = '0;
            end
          end
        end
      end
      OP_SHRINK: begin
        if (last_ix >= 0 && tbl_base[last_ix] == addr) begin
          nlen = (sz <= 0) ? 0 : ((sz + 7) & ~7);
          room = 65535 - int'(addr);
          if (nlen > room) nlen = room;
          tbl_len[last_ix] = nlen[15:0];
          bump_ptr = addr + nlen[15:0];
          r = '{status: ST_SHRUNK, base: addr, len: nlen[15:0], slot: last_ix[4:0]};
        end
      end
      default: r.status = ST_IGNORED;
    endcase
    return r;
  endfunction

  // Sends one request beat and records its expected result on acceptance.
  task automatic push_request(logic [1:0] op, logic signed [16:0] size,
                              logic [15:0] addr);
    grant_t want;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'b0, addr, size};
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_grant(op, size, addr);
    pending_grants.push_back(want);
    op_count[op]++;
  endtask

  // Bursts of back-to-back beats with random gaps between them.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(10, 80);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain_grants();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_buffer_size(logic [15:0] value);
    drain_grants();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    buf_size = value;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Chooses the next random request, mostly well formed against the shadow state.
  task automatic pick_request(output logic [1:0] op, output logic signed [16:0] size,
                              output logic [15:0] addr);
    int roll;
    int avail;
    int ix;
    int pick;
    int live [$];
    int holes [$];
    avail = (buf_size > bump_ptr) ? int'(buf_size) - int'(bump_ptr) : 0;
    roll = $urandom_range(0, 99);
    addr = 16'($urandom_range(0, 65535));
    size = 17'($urandom_range(1, 64));
    op = OP_ALLOC;
    for (ix = 0; ix < TBL_SLOTS; ix++) begin
      if (used_map[ix] && tbl_len[ix] != 0) live.push_back(ix);
      if (!used_map[ix] && tbl_len[ix] != 0 && (used_map >> ix) != 0) holes.push_back(ix);
    end
    if (roll < 42) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        size = 17'($urandom_range(1, 64));
      end else if (roll < 80) begin
        if (holes.size() != 0) size = 17'(tbl_len[holes[$urandom_range(0, holes.size() - 1)]]);
      end else if (roll < 86) begin
        size = 17'($urandom_range(65, (buf_size > 65) ? int'(buf_size) : 65));
      end else if (roll < 90) begin
        if (avail >= 16) size = 17'sd0;
      end else if (roll < 94) begin
        if (avail >= 16) size = -17'sd1;
      end else begin
        size = 17'($urandom_range(0, 65535));
      end
    end else if (roll < 74) begin
      op = OP_RELEASE;
      if (live.size() != 0) begin
        pick = live[$urandom_range(0, live.size() - 1)];
        addr = tbl_base[pick] + 16'($urandom_range(0, int'(tbl_len[pick]) - 1));
      end
    end else if (roll < 88) begin
      op = OP_SHRINK;
      if (last_ix >= 0) addr = tbl_base[last_ix];
      case ($urandom_range(0, 9))
        0:       size = -17'sd1;
        1:       size = 17'sd65535;
        2:       size = 17'($urandom_range(0, 65535));
        3:       size = 17'sd0;
        default: size = 17'($urandom_range(1, 2 * int'(tbl_len[(last_ix >= 0) ? last_ix : 0]) + 16));
      endcase
    end else begin
      // Noise: the spare code, blind addresses and out-of-range sizes.
      size = 17'($urandom_range(0, 131071));
      case ($urandom_range(0, 4))
        0: op = OP_SPARE;
        1: op = OP_RELEASE;
        2: op = OP_SHRINK;
        3: size = 17'($urandom_range(65536, 131070));
        default: op = OP_ALLOC;
      endcase
    end
  endtask

  task automatic run_random_traffic(int n_items);
    logic [1:0]         op;
    logic signed [16:0] size;
    logic [15:0]        addr;
    for (int i = 0; i < n_items; i++) begin
      pace_sender();
      pick_request(op, size, addr);
      push_request(op, size, addr);
      if (i % 173 == 172) drain_grants();
    end
  endtask

  // Special cases from reset with the default buffer size.
  task automatic test_directed_basics();
    push_request(OP_SHRINK, 17'sd16, 16'd0);         // shrink with no last block
    push_request(OP_RELEASE, 17'sd0, 16'd0);         // release in an empty table
    push_request(OP_SPARE, -17'sd1, 16'hFFFF);       // spare op code, all ones
    push_request(OP_ALLOC, -17'sd2, 16'd0);          // negative size below minus one
    push_request(OP_ALLOC, 17'h10000, 16'd0);        // most negative size
    push_request(OP_ALLOC, 17'sd100, 16'd0);
    push_request(OP_ALLOC, 17'sd65535, 16'd0);       // does not fit
    push_request(OP_ALLOC, 17'sd200, 16'd0);
    push_request(OP_ALLOC, 17'sd50, 16'd0);
    push_request(OP_RELEASE, 17'sd0, 16'd150);       // misses the last block first
    push_request(OP_SHRINK, 17'sd8, 16'd300);        // last block was forgotten
    push_request(OP_ALLOC, 17'sd200, 16'd0);         // exact-size hole is reused
    push_request(OP_ALLOC, 17'sd77, 16'd0);
    push_request(OP_SHRINK, 17'sd77, 16'd350);       // rounds up to eight
    push_request(OP_SHRINK, 17'sd5, 16'd0);          // not the base of the last block
    push_request(OP_RELEASE, 17'sd0, 16'd350);       // fast-path hit on the top block
    push_request(OP_ALLOC, -17'sd1, 16'd0);          // half of the free space
    push_request(OP_ALLOC, 17'sd0, 16'd0);           // all of the free space
    push_request(OP_ALLOC, 17'sd1, 16'd0);           // nothing left
    push_request(OP_SHRINK, -17'sd1, 16'd1175);      // shrink to zero
    push_request(OP_RELEASE, 17'sd0, 16'd0);
    push_request(OP_RELEASE, 17'sd0, 16'd1175);      // zero-length block holds nothing
    push_request(OP_RELEASE, 17'sd0, 16'd1174);      // last byte of a block
  endtask

  task automatic test_default_buffer_traffic();
    run_random_traffic(700);
  endtask

  task automatic test_full_range_buffer();
    write_buffer_size(16'hFFFF);
    run_random_traffic(500);
  endtask

  task automatic test_tight_buffer();
    write_buffer_size(16'd300);
    run_random_traffic(400);
    write_buffer_size(16'($urandom_range(1, 65535)));
    run_random_traffic(300);
  endtask

  // A zero-sized buffer carves only empty blocks from the bump pointer.
  task automatic test_empty_buffer();
    write_buffer_size(16'd0);
    push_request(OP_ALLOC, 17'sd5, 16'd0);
    push_request(OP_ALLOC, -17'sd1, 16'd0);
    push_request(OP_SHRINK, 17'sd9, bump_ptr);
    write_buffer_size(BUF_BYTES_RESET);
    push_request(OP_ALLOC, 17'sd24, 16'd0);
  endtask

  // Receiver readiness: always ready, random, or a periodic stall.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 99) < 55);
      default: m_axis_tready <= ((rx_phase % 7) < 4);
    endcase
  end

  // Compares each accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin : check_grant
    grant_t got;
    grant_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{status: status_e'(m_axis_tuser), base: m_axis_tdata[15:0],
              len: m_axis_tdata[31:16], slot: m_axis_tdata[36:32]};
      if (pending_grants.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("%0t: result beat with nothing pending: status %0d base %0d len %0d slot %0d",
                   $realtime, got.status, got.base, got.len, got.slot);
      end else begin
        want = pending_grants.pop_front();
        checked++;
        status_hist[int'(want.status)]++;
        if (got.status !== want.status || got.base !== want.base ||
            got.len !== want.len || got.slot !== want.slot) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("%0t: mismatch: expected status %0d base %0d len %0d slot %0d, got status %0d base %0d len %0d slot %0d",
                     $realtime, want.status, want.base, want.len, want.slot,
                     got.status, got.base, got.len, got.slot);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles, %0d results outstanding",
               cycle_count, pending_grants.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int errors;
    used_map = '0;
    for (int i = 0; i < TBL_SLOTS; i++) begin
      tbl_base[i] = '0;
      tbl_len[i]  = '0;
    end
    bump_ptr = '0;
    last_ix  = -1;
    buf_size = BUF_BYTES_RESET;
    for (int i = 0; i < 4; i++) op_count[i] = 0;
    for (int i = 0; i < 8; i++) status_hist[i] = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_basics();
    test_default_buffer_traffic();
    test_full_range_buffer();
    test_tight_buffer();
    test_empty_buffer();

    drain_grants();
    repeat (2 * TBL_SLOTS + 8) @(posedge clk_i);

    errors = mismatches + unexpected + pending_grants.size();
    $display("Sent %0d allocate, %0d release, %0d shrink, %0d spare requests; %0d size writes",
             op_count[0], op_count[1], op_count[2], op_count[3], cfg_writes);
    $display("Checked %0d results: new %0d reused %0d no-space %0d released %0d not-found %0d shrunk %0d ignored %0d; %0d errors",
             checked, status_hist[0], status_hist[1], status_hist[2], status_hist[3],
             status_hist[4], status_hist[5], status_hist[6], errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
